### design/ppm_input_decoder_assert.svh
// ----------------------------------------------------------------------------
// PPM input decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PPM_INPUT_DECODER_ASSERT_SVH
`define PPM_INPUT_DECODER_ASSERT_SVH

// Same-cycle implication.
`define PPM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppm_input_decoder: assertion failed");

// Next-cycle implication.
`define PPM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppm_input_decoder: assertion failed");

`endif

### design/ppm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM decoder package
// Register indexes, reset values, limits and the result record.
// ----------------------------------------------------------------------------
package ppm_pkg;

	localparam int unsigned MaxChannels = 20;
	localparam int unsigned QueueDepth  = 4;

	localparam logic [5:0]  CntSat          = 6'd63;
	localparam logic [15:0] MinWidthReset   = 16'd1800;
	localparam logic [15:0] MaxWidthReset   = 16'd4200;
	localparam logic [15:0] SyncWidthReset  = 16'd5500;
	localparam logic [15:0] CounterTopReset = 16'd65535;

	localparam logic KindSample = 1'b0;
	localparam logic KindSync   = 1'b1;

	typedef enum logic [2:0] {
		REG_MIN_WIDTH   = 3'd0,
		REG_MAX_WIDTH   = 3'd1,
		REG_SYNC_WIDTH  = 3'd2,
		REG_COUNTER_TOP = 3'd3,
		REG_SKIP_CHAN_A = 3'd4,
		REG_SKIP_CHAN_B = 3'd5,
		REG_SKIP_CHAN_C = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] min_width;
		logic [15:0] max_width;
		logic [15:0] sync_width;
		logic [15:0] counter_top;
		logic [4:0]  skip_chan_a;
		logic [4:0]  skip_chan_b;
		logic [4:0]  skip_chan_c;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  channel_index;
		logic [15:0] pulse_width;
		logic [5:0]  channels_seen;
	} result_t;

endpackage

### design/ppm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM decoder channel interfaces
// Capture input, result output and register write channels.
// ----------------------------------------------------------------------------
interface ppm_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] capture_time;

	modport source (output valid, output capture_time, input ready);
	modport sink (input valid, input capture_time, output ready);
endinterface

interface ppm_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [4:0]  channel_index;
	logic [15:0] pulse_width;
	logic [5:0]  channels_seen;

	modport source (output valid, output kind, output channel_index, output pulse_width,
		output channels_seen, input ready);
	modport sink (input valid, input kind, input channel_index, input pulse_width,
		input channels_seen, output ready);
endinterface

interface ppm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/ppm_input_decoder.sv
// Path: an accepted capture is registered in the interval stage, then pushed
// into the queue, then loaded into the output register that drives the result
// channel.
// Throughput: one capture per cycle; the front end stalls only when the queue is
// full and the queue fills only while the output channel is held off.
// Reset: arst_n clears the previous timestamp, channel counter, queue and output
// valid, and loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM input decoder
// Decodes a PPM pulse train from input-capture timestamps into channel samples
// and frame sync reports.
// ----------------------------------------------------------------------------
module ppm_input_decoder #(
	parameter int unsigned QUEUE_DEPTH = ppm_pkg::QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	ppm_in_if.sink    capture,
	ppm_cfg_if.sink   cfg,
	ppm_out_if.source result
);
	import ppm_pkg::*;

	// Register file. Writes are taken every cycle; the decoder is expected to be
	// idle whenever a register changes, so no shadowing is done here.
	cfg_t    cfg_q;

	// Request path from the front end through the queue to the output register.
	result_t push_data;
	logic    push_valid;
	logic    push_ready;
	result_t pop_data;
	logic    pop_valid;
	logic    pop_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_width   <= MinWidthReset;
			cfg_q.max_width   <= MaxWidthReset;
			cfg_q.sync_width  <= SyncWidthReset;
			cfg_q.counter_top <= CounterTopReset;
			cfg_q.skip_chan_a <= '0;
			cfg_q.skip_chan_b <= '0;
			cfg_q.skip_chan_c <= '0;
		end else if (cfg.valid && cfg.ready) begin
			// Indexes past the last register fall into the default arm and are dropped.
			case (cfg_reg_t'(cfg.index))
				REG_MIN_WIDTH: begin
					cfg_q.min_width <= cfg.data;
				end
				REG_MAX_WIDTH: begin
					cfg_q.max_width <= cfg.data;
				end
				REG_SYNC_WIDTH: begin
					cfg_q.sync_width <= cfg.data;
				end
				REG_COUNTER_TOP: begin
					cfg_q.counter_top <= cfg.data;
				end
				REG_SKIP_CHAN_A: begin
					cfg_q.skip_chan_a <= cfg.data[4:0];
				end
				REG_SKIP_CHAN_B: begin
					cfg_q.skip_chan_b <= cfg.data[4:0];
				end
				REG_SKIP_CHAN_C: begin
					cfg_q.skip_chan_c <= cfg.data[4:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The front end measures each interval, then classifies it against the
	// thresholds while it owns the channel counter. Only items that produce a
	// result are pushed; excluded channels and short pulses stop here.
	ppm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.capture    (capture),
		.cfg_regs   (cfg_q),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// The queue decouples the two sides so that a stalled output does not
	// immediately stop capture intake.
	ppm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// The output register accepts a new result in the same cycle the previous
	// one is taken.
	ppm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule

### design/ppm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM decoder front end
// Measures edge intervals, classifies them and keeps the channel counter.
// ----------------------------------------------------------------------------
`include "ppm_input_decoder_assert.svh"

module ppm_front (
	input  logic           clk,
	input  logic           arst_n,
	ppm_in_if.sink         capture,
	input  ppm_pkg::cfg_t  cfg_regs,
	output ppm_pkg::result_t push_data,
	output logic           push_valid,
	input  logic           push_ready
);
	import ppm_pkg::*;

	logic [15:0] prev_capture_q;
	logic [5:0]  chan_cnt_q;
	logic        valid_s1;
	logic [15:0] width_s1;

	logic [15:0] width_d;
	logic        is_sync;
	logic        in_range;
	logic        above_min;
	logic        excluded;
	logic [4:0]  chan_one;
	logic        adv_s1;

	// Interval with wrap at the timer top, kept modulo 2^16.
	always_comb begin
		if (prev_capture_q > capture.capture_time) begin
			width_d = 16'(capture.capture_time + cfg_regs.counter_top - prev_capture_q);
		end else begin
			width_d = 16'(capture.capture_time - prev_capture_q);
		end
	end

	always_comb begin
		is_sync   = width_s1 > cfg_regs.sync_width;
		above_min = width_s1 > cfg_regs.min_width;
		in_range  = (chan_cnt_q < 6'(MaxChannels)) && above_min &&
			(width_s1 < cfg_regs.max_width);
		chan_one  = 5'(chan_cnt_q) + 5'd1;
		excluded  = (chan_one == cfg_regs.skip_chan_a) ||
			(chan_one == cfg_regs.skip_chan_b) ||
			(chan_one == cfg_regs.skip_chan_c);
	end

	always_comb begin
		push_data = '0;
		push_data.pulse_width = width_s1;
		if (is_sync) begin
			push_data.kind          = KindSync;
			push_data.channels_seen = chan_cnt_q;
		end else begin
			push_data.kind          = KindSample;
			push_data.channel_index = 5'(chan_cnt_q);
		end
	end

	assign push_valid    = valid_s1 && (is_sync || (in_range && !excluded));
	assign adv_s1        = valid_s1 && (push_ready || !push_valid);
	assign capture.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_capture_q <= '0;
			chan_cnt_q     <= '0;
			valid_s1       <= 1'b0;
		end else begin
			if (capture.valid && capture.ready) begin
				prev_capture_q <= capture.capture_time;
				valid_s1       <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				if (is_sync) begin
					chan_cnt_q <= '0;
				end else if (above_min && chan_cnt_q < CntSat) begin
					chan_cnt_q <= chan_cnt_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture.valid && capture.ready) begin
			width_s1 <= width_d;
		end
	end

	`PPM_ASSERT_NEXT(a_sync_clears_count, adv_s1 && is_sync, chan_cnt_q == 6'd0)
	`PPM_ASSERT_IMPL(a_sample_in_frame, push_valid && push_data.kind == KindSample,
		push_data.channel_index < 5'(MaxChannels))

endmodule

### design/ppm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM decoder result queue
// Small first-in first-out buffer between front end and output stage.
// ----------------------------------------------------------------------------
`include "ppm_input_decoder_assert.svh"

module ppm_queue #(
	parameter int unsigned DEPTH = ppm_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ppm_pkg::result_t push_data,
	input  logic             push_valid,
	output logic             push_ready,
	output ppm_pkg::result_t pop_data,
	output logic             pop_valid,
	input  logic             pop_ready
);
	import ppm_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	result_t         entries_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != CntW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	`PPM_ASSERT_IMPL(a_count_bounded, 1'b1, count_q <= CntW'(DEPTH))
	`PPM_ASSERT_NEXT(a_count_grows, do_push && !do_pop, count_q == $past(count_q) + 1'b1)

endmodule

### design/ppm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM decoder output stage
// Registers the queue head and presents it on the result channel.
// ----------------------------------------------------------------------------
module ppm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ppm_pkg::result_t pop_data,
	input  logic             pop_valid,
	output logic             pop_ready,
	ppm_out_if.source        result
);
	import ppm_pkg::*;

	logic    out_valid_q;
	result_t out_data_q;

	assign pop_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			out_data_q <= pop_data;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.kind          = out_data_q.kind;
	assign result.channel_index = out_data_q.channel_index;
	assign result.pulse_width   = out_data_q.pulse_width;
	assign result.channels_seen = out_data_q.channels_seen;

endmodule

### tb/ppm_input_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM input decoder testbench
// Feeds capture timestamps shaped as PPM frames with random content, plus
// noise, through several register settings and handshake idling patterns.
// A frame tracker predicts every channel sample and sync report and checks
// each result leaving the block in order, field by field.
// ----------------------------------------------------------------------------
module ppm_input_decoder_tb;
	import ppm_pkg::*;

	// The register port is three bits wide; the top index names no register and
	// a write to it must be ignored.
	localparam logic [2:0] RegUnused = 3'd7;

	// Settle time after the last expected result before the registers change or
	// the run ends, with margin for captures in flight that produce nothing.
	localparam int SettleCycles = 8;

	// Frame tracker: keeps its own copy of the registers, the last timestamp and
	// the channel counter, and turns each accepted capture into the result the
	// block must produce, if any.
	class ppm_frame_tracker;
		cfg_t        cfg;
		logic [15:0] last_capture;
		logic [5:0]  chan_cnt;
		result_t     pending_reports[$];
		int          errors;

		function new();
			cfg.min_width   = MinWidthReset;
			cfg.max_width   = MaxWidthReset;
			cfg.sync_width  = SyncWidthReset;
			cfg.counter_top = CounterTopReset;
			cfg.skip_chan_a = '0;
			cfg.skip_chan_b = '0;
			cfg.skip_chan_c = '0;
			last_capture    = '0;
			chan_cnt        = '0;
			errors          = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				REG_MIN_WIDTH:   cfg.min_width   = data;
				REG_MAX_WIDTH:   cfg.max_width   = data;
				REG_SYNC_WIDTH:  cfg.sync_width  = data;
				REG_COUNTER_TOP: cfg.counter_top = data;
				REG_SKIP_CHAN_A: cfg.skip_chan_a = data[4:0];
				REG_SKIP_CHAN_B: cfg.skip_chan_b = data[4:0];
				REG_SKIP_CHAN_C: cfg.skip_chan_c = data[4:0];
				default: ;
			endcase
		endfunction

		function void bump_count();
			if (chan_cnt < CntSat)
				chan_cnt++;
		endfunction

		function void note_capture(logic [15:0] cap);
			logic [15:0] width;
			logic [5:0]  chan;
			logic [5:0]  one_based;
			// A timestamp below the previous one means the capture timer wrapped
			// at its top; the sum is kept to 16 bits.
			if (last_capture > cap)
				width = cap + cfg.counter_top - last_capture;
			else
				width = cap - last_capture;
			last_capture = cap;

			if (width > cfg.sync_width) begin
				pending_reports.push_back({KindSync, 5'd0, width, chan_cnt});
				chan_cnt = '0;
				return;
			end

			if (chan_cnt < MaxChannels && width > cfg.min_width && width < cfg.max_width) begin
				chan = chan_cnt;
				bump_count();
				one_based = chan + 6'd1;
				if (one_based == {1'b0, cfg.skip_chan_a} || one_based == {1'b0, cfg.skip_chan_b} ||
						one_based == {1'b0, cfg.skip_chan_c})
					return;
				pending_reports.push_back({KindSample, chan[4:0], width, 6'd0});
				return;
			end

			// Out of range but long enough to be a pulse: the slot still counts.
			if (width > cfg.min_width)
				bump_count();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("MISMATCH at %0t ns: %s", $time, msg);
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_reports.size() == 0) begin
				report($sformatf("result kind=%0d ch=%0d width=%0d seen=%0d with none pending",
					got.kind, got.channel_index, got.pulse_width, got.channels_seen));
				return;
			end
			want = pending_reports.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, predicted %0d", got.kind, want.kind));
			if (got.channel_index !== want.channel_index)
				report($sformatf("channel_index %0d, predicted %0d",
					got.channel_index, want.channel_index));
			if (got.pulse_width !== want.pulse_width)
				report($sformatf("pulse_width %0d, predicted %0d",
					got.pulse_width, want.pulse_width));
			if (got.channels_seen !== want.channels_seen)
				report($sformatf("channels_seen %0d, predicted %0d",
					got.channels_seen, want.channels_seen));
		endtask

		function int pending();
			return pending_reports.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ppm_in_if  cap_if ();
	ppm_out_if res_if ();
	ppm_cfg_if cfg_if ();

	ppm_input_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.capture(cap_if),
		.cfg    (cfg_if),
		.result (res_if)
	);

	ppm_frame_tracker tracker = new();

	// Handshake pressure knobs, in percent, set per phase by the main sequence.
	int          capture_idle_pct = 0;
	int          result_stall_pct = 0;
	// Cycles left of a forced hold-off on the result side.
	int          hold_cycles      = 0;
	int          items_sent       = 0;
	// Free-running timestamp that the frame generator advances.
	logic [15:0] stamp            = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: ready is owned here alone. A hold-off keeps it low for a
	// counted stretch so that the internal queue fills and the block stalls its
	// capture input.
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= result_stall_pct);
			end
		end
	end

	// Every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			tracker.check_result({res_if.kind, res_if.channel_index, res_if.pulse_width,
				res_if.channels_seen});
	end

	// Offers one capture, with random idle cycles in front of it, and returns at
	// the step of its acceptance with valid still high. The caller must assign
	// valid in that same step, either with the next request or by lowering it.
	task automatic send_capture(input logic [15:0] cap);
		while ($urandom_range(99) < capture_idle_pct) begin
			cap_if.valid <= 1'b0;
			@(posedge clk);
		end
		cap_if.valid        <= 1'b1;
		cap_if.capture_time <= cap;
		@(posedge clk);
		while (!cap_if.ready)
			@(posedge clk);
		tracker.note_capture(cap);
		items_sent++;
	endtask

	// Advances the timestamp by an interval, folding at the counter top the way
	// a capture timer would, so that the measured width mostly equals the step.
	task automatic send_interval(input logic [15:0] delta);
		int unsigned sum;
		sum = stamp + delta;
		if (tracker.cfg.counter_top > 16'd1000 && sum > tracker.cfg.counter_top)
			sum = sum - tracker.cfg.counter_top;
		stamp = 16'(sum);
		send_capture(stamp);
	endtask

	// Lowers valid, waits until every prediction has been matched, then lets the
	// pipeline settle so that no capture is still in flight.
	task automatic drain();
		cap_if.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	// Writes the whole register set back to back. With poke_unused set, a write
	// to the index past the list is slipped in; it must change nothing.
	task automatic program_regs(input cfg_t c, input bit poke_unused);
		write_reg(REG_MIN_WIDTH, c.min_width);
		if (poke_unused)
			write_reg(RegUnused, 16'hFFFF);
		write_reg(REG_MAX_WIDTH, c.max_width);
		write_reg(REG_SYNC_WIDTH, c.sync_width);
		write_reg(REG_COUNTER_TOP, c.counter_top);
		write_reg(REG_SKIP_CHAN_A, {11'd0, c.skip_chan_a});
		write_reg(REG_SKIP_CHAN_B, {11'd0, c.skip_chan_b});
		write_reg(REG_SKIP_CHAN_C, {11'd0, c.skip_chan_c});
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_between(input int lo, input int hi);
		if (hi > 65535)
			hi = 65535;
		if (lo > hi)
			return 16'($urandom);
		return 16'($urandom_range(hi, lo));
	endfunction

	// One channel interval: mostly a valid pulse, otherwise a short glitch, an
	// out-of-range pulse, an exact threshold or plain noise.
	function automatic logic [15:0] channel_interval();
		int pick;
		int mn;
		int mx;
		int sy;
		pick = $urandom_range(99);
		mn   = tracker.cfg.min_width;
		mx   = tracker.cfg.max_width;
		sy   = tracker.cfg.sync_width;
		if (pick < 80)
			return pick_between(mn + 1, mx - 1);
		if (pick < 87)
			return pick_between(0, mn);
		if (pick < 93)
			return pick_between(mx, sy);
		if (pick < 97) begin
			case ($urandom_range(2))
				0: return 16'(mn);
				1: return 16'(mx);
				default: return 16'(sy);
			endcase
		end
		return 16'($urandom);
	endfunction

	// Well-formed frames with random content: a sync gap, then a run of
	// channels. Some frames run past the channel limit, and a few far enough to
	// saturate the counter.
	task automatic run_frames(input int budget);
		int target;
		int chans;
		int sy;
		target = items_sent + budget;
		while (items_sent < target) begin
			sy = tracker.cfg.sync_width;
			if ($urandom_range(99) < 90)
				send_interval(pick_between(sy + 1, sy + 3000));
			else
				send_interval(16'($urandom));
			chans = ($urandom_range(99) < 12) ? $urandom_range(70, 21) :
				$urandom_range(MaxChannels, 1);
			for (int k = 0; k < chans && items_sent < target; k++)
				send_interval(channel_interval());
		end
	endtask

	initial begin
		cfg_t c;

		arst_n              <= 1'b0;
		cap_if.valid        <= 1'b0;
		cap_if.capture_time <= '0;
		cfg_if.valid        <= 1'b0;
		cfg_if.index        <= REG_MIN_WIDTH;
		cfg_if.data         <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed captures under the reset register values (min 1800, max 4200,
		// sync 5500, top 65535). Zero width first, then the largest width as a
		// sync on an empty frame, a wrap past the timer top, and widths sitting
		// exactly on and just inside each threshold.
		send_capture(16'd0);      // zero width: nothing
		send_capture(16'hFFFF);   // widest interval: sync with no channels
		send_capture(16'd2000);   // wrapped, width 2000: channel 0
		send_capture(16'd5000);   // width 3000: channel 1
		send_capture(16'd6800);   // exactly min: short, counter holds
		send_capture(16'd11000);  // exactly max: counted, no sample
		send_capture(16'd16500);  // exactly sync: counted, no sample
		send_capture(16'd18301);  // just above min: channel 4
		send_capture(16'd22500);  // just below max: channel 5
		send_capture(16'd28001);  // just above sync: frame of six
		send_capture(16'd28001);  // same stamp again: zero width
		send_capture(16'd100);    // wrap with a width well above sync
		stamp = 16'd100;

		// Reset values, no idling on either side.
		run_frames(160);
		drain();

		// Narrow windows, a low timer top and three excluded channels, one of them
		// at the top of the channel range. The sender idles.
		c = '{16'd1000, 16'd2000, 16'd3000, 16'd40000, 5'd1, 5'd20, 5'd10};
		program_regs(c, 1'b1);
		capture_idle_pct = 46;
		run_frames(170);
		drain();

		// Widest window and no sync ever: frames run on until the counter
		// saturates. Timer top of zero, and skip values that name no channel.
		// The receiver stalls.
		c = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 5'd0, 5'd31, 5'd25};
		program_regs(c, 1'b0);
		capture_idle_pct = 0;
		result_stall_pct = 46;
		run_frames(170);
		drain();

		// Nothing can be a pulse and every nonzero width is a sync. Both sides
		// idle a little.
		c = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 5'd20, 5'd0, 5'd19};
		program_regs(c, 1'b0);
		capture_idle_pct = 8;
		result_stall_pct = 8;
		run_frames(170);
		drain();

		// Typical timing with one channel excluded twice over. The receiver is
		// held off for a long stretch while captures keep coming, so the queue
		// fills and the capture input must stall.
		c = '{16'd1800, 16'd4200, 16'd5500, 16'hFFFF, 5'd3, 5'd3, 5'd0};
		program_regs(c, 1'b0);
		capture_idle_pct = 0;
		result_stall_pct = 0;
		hold_cycles      = 300;
		run_frames(170);
		drain();

		// Random register values, sender idling.
		c.min_width   = 16'($urandom_range(3000));
		c.max_width   = 16'($urandom_range(8000, c.min_width));
		c.sync_width  = 16'($urandom_range(20000, c.max_width));
		c.counter_top = 16'($urandom);
		c.skip_chan_a = 5'($urandom_range(20));
		c.skip_chan_b = 5'($urandom_range(20));
		c.skip_chan_c = 5'($urandom_range(20));
		program_regs(c, 1'b0);
		capture_idle_pct = 46;
		result_stall_pct = 0;
		run_frames(170);
		drain();

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: fails the run after a delay far beyond what the slowest correct
	// run needs.
	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/ppm_pkg.sv
design/ppm_if.sv
design/ppm_front.sv
design/ppm_queue.sv
design/ppm_back.sv
design/ppm_input_decoder.sv
tb/ppm_input_decoder_tb.sv
